// ----- sv/bgc_pkg.sv -----
// ----------------------------------------------------------------------------
// bgc_pkg
// Shared types, register indexes and helper functions for the button gesture
// classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package bgc_pkg;

   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 16;

   typedef enum logic [CSR_ADDR_WIDTH-1:0] {
      REG_SHORT_LIMIT       = 3'd0,
      REG_LONG_LIMIT        = 3'd1,
      REG_WINDOW_TICKS      = 3'd2,
      REG_BLINK_TICKS       = 3'd3,
      REG_MANY_CLICKS_LIMIT = 3'd4
   } reg_index_type;

   localparam logic [15:0] SHORT_LIMIT_RESET       = 16'd50;
   localparam logic [15:0] LONG_LIMIT_RESET        = 16'd400;
   localparam logic [15:0] WINDOW_TICKS_RESET      = 16'd200;
   localparam logic [15:0] BLINK_TICKS_RESET       = 16'd30;
   localparam logic [7:0]  MANY_CLICKS_LIMIT_RESET = 8'd3;

   typedef struct packed {
      logic [15:0] short_limit;
      logic [15:0] long_limit;
      logic [15:0] window_ticks;
      logic [15:0] blink_ticks;
      logic [7:0]  many_clicks_limit;
   } cfg_type;

   typedef enum logic [1:0] {
      MODE_IDLE   = 2'd0,
      MODE_LONG   = 2'd1,
      MODE_MEDIUM = 2'd2
   } mode_type;

   typedef struct packed {
      logic        led_a;
      logic        led_b;
      logic        held;
      logic [15:0] last_press_ticks;
      logic [7:0]  clicks_latched;
   } result_type;

   function automatic logic [15:0] sat_inc16(input logic [15:0] v);
      return (v == 16'hFFFF) ? v : v + 16'd1;
   endfunction

   function automatic mode_type mode_of(input logic [15:0] duration, input cfg_type cfg);
      if (duration > cfg.long_limit) begin
         return MODE_LONG;
      end else if (duration >= cfg.short_limit) begin
         return MODE_MEDIUM;
      end
      return MODE_IDLE;
   endfunction

endpackage

`default_nettype wire

// ----- sv/bgc_csr.sv -----
// ----------------------------------------------------------------------------
// bgc_csr
// Configuration register file with a plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module bgc_csr (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_we,
   input  wire logic [bgc_pkg::CSR_ADDR_WIDTH-1:0]  csr_addr,
   input  wire logic [bgc_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata,
   output bgc_pkg::cfg_type                         cfg
);

   bgc_pkg::cfg_type cfg_ff;
   bgc_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_addr)
            bgc_pkg::REG_SHORT_LIMIT:       cfg_in.short_limit       = csr_wdata;
            bgc_pkg::REG_LONG_LIMIT:        cfg_in.long_limit        = csr_wdata;
            bgc_pkg::REG_WINDOW_TICKS:      cfg_in.window_ticks      = csr_wdata;
            bgc_pkg::REG_BLINK_TICKS:       cfg_in.blink_ticks       = csr_wdata;
            bgc_pkg::REG_MANY_CLICKS_LIMIT: cfg_in.many_clicks_limit = csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.short_limit       <= bgc_pkg::SHORT_LIMIT_RESET;
         cfg_ff.long_limit        <= bgc_pkg::LONG_LIMIT_RESET;
         cfg_ff.window_ticks      <= bgc_pkg::WINDOW_TICKS_RESET;
         cfg_ff.blink_ticks       <= bgc_pkg::BLINK_TICKS_RESET;
         cfg_ff.many_clicks_limit <= bgc_pkg::MANY_CLICKS_LIMIT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ----- sv/bgc_core.sv -----
// ----------------------------------------------------------------------------
// bgc_core
// Gesture state and its update for one tick or button edge, taken when step is high.
// ----------------------------------------------------------------------------
`default_nettype none

module bgc_core (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          step,
   input  wire logic          action,
   input  wire logic          button_level,
   input  bgc_pkg::cfg_type   cfg,
   output bgc_pkg::result_type result
);

   logic        pressed_ff, pressed_in;
   logic [15:0] press_count_ff, press_count_in;
   logic [15:0] last_duration_ff, last_duration_in;
   logic        window_active_ff, window_active_in;
   logic [15:0] window_count_ff, window_count_in;
   logic [7:0]  click_count_ff, click_count_in;
   logic [7:0]  click_total_ff, click_total_in;
   logic [15:0] blink_count_ff, blink_count_in;
   logic        led_a_ff, led_a_in;
   logic        led_b_ff, led_b_in;

   bgc_pkg::mode_type release_mode;
   bgc_pkg::mode_type tick_mode;
   bgc_pkg::mode_type final_mode;

   always_comb begin
      pressed_in       = pressed_ff;
      press_count_in   = press_count_ff;
      last_duration_in = last_duration_ff;
      window_active_in = window_active_ff;
      window_count_in  = window_count_ff;
      click_count_in   = click_count_ff;
      click_total_in   = click_total_ff;
      blink_count_in   = blink_count_ff;
      led_a_in         = led_a_ff;
      led_b_in         = led_b_ff;
      release_mode     = bgc_pkg::mode_of(press_count_ff, cfg);
      tick_mode        = bgc_pkg::mode_of(last_duration_ff, cfg);

      if (action) begin
         if (!button_level) begin
            if (!pressed_ff) begin
               pressed_in     = 1'b1;
               press_count_in = '0;
            end
         end else if (pressed_ff) begin
            pressed_in       = 1'b0;
            last_duration_in = press_count_ff;
            press_count_in   = '0;
            if (press_count_ff < cfg.short_limit) begin
               if (!window_active_ff) begin
                  window_active_in = 1'b1;
                  window_count_in  = '0;
               end
               if (click_count_ff != 8'hFF) begin
                  click_count_in = click_count_ff + 8'd1;
               end
            end
            if (release_mode != bgc_pkg::MODE_IDLE) begin
               if (click_total_ff != '0) begin
                  led_a_in = (click_total_ff > cfg.many_clicks_limit);
                  led_b_in = (click_total_ff <= cfg.many_clicks_limit);
               end
               if (release_mode == bgc_pkg::MODE_LONG) begin
                  led_b_in = 1'b1;
                  led_a_in = !led_a_in;
               end else begin
                  led_a_in = 1'b1;
                  led_b_in = !led_b_in;
               end
               blink_count_in = '0;
            end
         end
      end else begin
         if (pressed_ff) begin
            press_count_in   = bgc_pkg::sat_inc16(press_count_ff);
            last_duration_in = press_count_in;
         end
         if (window_active_ff) begin
            window_count_in = bgc_pkg::sat_inc16(window_count_ff);
            if (window_count_in >= cfg.window_ticks) begin
               click_total_in   = click_count_ff;
               click_count_in   = '0;
               window_active_in = 1'b0;
               window_count_in  = '0;
            end
         end
         if (!pressed_ff && tick_mode != bgc_pkg::MODE_IDLE) begin
            blink_count_in = bgc_pkg::sat_inc16(blink_count_ff);
            if (blink_count_in >= cfg.blink_ticks) begin
               if (tick_mode == bgc_pkg::MODE_LONG) begin
                  led_b_in = 1'b1;
                  led_a_in = !led_a_ff;
               end else begin
                  led_a_in = 1'b1;
                  led_b_in = !led_b_ff;
               end
               blink_count_in = '0;
            end
         end
      end

      final_mode = bgc_pkg::mode_of(last_duration_in, cfg);
      if (!pressed_in && final_mode == bgc_pkg::MODE_IDLE && click_total_in != '0) begin
         led_a_in = (click_total_in > cfg.many_clicks_limit);
         led_b_in = (click_total_in <= cfg.many_clicks_limit);
      end

      result.led_a            = led_a_in;
      result.led_b            = led_b_in;
      result.held             = pressed_in;
      result.last_press_ticks = last_duration_in;
      result.clicks_latched   = click_total_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pressed_ff       <= 1'b0;
         press_count_ff   <= '0;
         last_duration_ff <= '0;
         window_active_ff <= 1'b0;
         window_count_ff  <= '0;
         click_count_ff   <= '0;
         click_total_ff   <= '0;
         blink_count_ff   <= '0;
         led_a_ff         <= 1'b0;
         led_b_ff         <= 1'b0;
      end else if (step) begin
         pressed_ff       <= pressed_in;
         press_count_ff   <= press_count_in;
         last_duration_ff <= last_duration_in;
         window_active_ff <= window_active_in;
         window_count_ff  <= window_count_in;
         click_count_ff   <= click_count_in;
         click_total_ff   <= click_total_in;
         blink_count_ff   <= blink_count_in;
         led_a_ff         <= led_a_in;
         led_b_ff         <= led_b_in;
      end
   end

endmodule

`default_nettype wire

// ----- sv/button_gesture_classifier_top.sv -----
// ----------------------------------------------------------------------------
// button_gesture_classifier_top
// Click, medium press and long press detector for an active-low button.
// ----------------------------------------------------------------------------
// Each word on the req_ channel is one event: a 10 ms base tick or a button
// edge with the pin level. For every accepted word exactly one word leaves on
// the rsp_ channel with both LED levels, the held flag, the latest press
// duration and the click total of the last completed window.
// The block has two register stages: an input register and a result register.
// The gesture state updates in the cycle that moves a word from the input
// register into the result register, so a result reaches rsp_tvalid once
// that move has happened, which waits while the result register is full
// and stalled. One word per cycle is sustained while rsp_tready stays high;
// the state update is the only loop.
// When rsp_tready is low the result register holds its word and the input
// register still takes one more word; req_tready drops only when both are
// full. Synchronous reset empties both stages, clears all gesture state and
// loads the register defaults. The csr_ port writes a register at any clock
// edge with csr_we high; it is meant to be used while no word is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module button_gesture_classifier_top (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   input  wire logic [7:0]                          req_tdata,  // action, button_level
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // led_a, led_b, held, last_press_ticks[15:0], clicks_latched[7:0]
   output logic [31:0]                              rsp_tdata,
   input  wire logic                                csr_we,
   input  wire logic [bgc_pkg::CSR_ADDR_WIDTH-1:0]  csr_addr,
   input  wire logic [bgc_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata
);

   bgc_pkg::cfg_type    cfg;
   bgc_pkg::result_type result;

   logic                in_valid_ff, in_valid_in;
   logic                in_action_ff;
   logic                in_level_ff;
   logic                out_valid_ff, out_valid_in;
   bgc_pkg::result_type out_data_ff;
   logic                advance;
   logic                req_take;

   bgc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   bgc_core u_core (
      .clock        (clock),
      .reset        (reset),
      .step         (advance),
      .action       (in_action_ff),
      .button_level (in_level_ff),
      .cfg          (cfg),
      .result       (result)
   );

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_action_ff <= req_tdata[0];
         in_level_ff  <= req_tdata[1];
      end
      if (advance) begin
         out_data_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {5'd0,
                        out_data_ff.clicks_latched,
                        out_data_ff.last_press_ticks,
                        out_data_ff.held,
                        out_data_ff.led_b,
                        out_data_ff.led_a};

   a_result_from_input : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(in_valid_ff))
      else $error("result appeared without a buffered input word");

   a_stall_keeps_input : assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && rsp_tvalid && !rsp_tready) |=> in_valid_ff)
      else $error("input word lost while the result register was stalled");

   a_reset_empties : assert property (@(posedge clock)
      reset |=> (!in_valid_ff && !rsp_tvalid))
      else $error("pipeline not empty after reset");

endmodule

`default_nettype wire

// ----- tb/sv/tb_button_gesture_classifier_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_button_gesture_classifier_top
// Self-checking testbench for the button gesture classifier.
// ----------------------------------------------------------------------------
// Every event word sent on the req_ stream is run through a gesture model
// held here; its prediction, or a scripted row's typed result, is queued.
// Each word taken from the rsp_ stream is compared field by field with the
// oldest queued result. A short scripted sequence comes first, then random
// press, hold and release gestures mixed with stray edges and ticks, under
// several register settings and several patterns of sender gaps and receiver
// stalls. A short run with every register at its maximum value is included.
// ----------------------------------------------------------------------------

module tb_button_gesture_classifier_top;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int HOLD_OFF_CYCLES = 300;

   typedef struct {
      logic        pressed;
      logic        window_open;
      logic        led_a;
      logic        led_b;
      logic [15:0] press_ticks;
      logic [15:0] duration;
      logic [15:0] window_age;
      logic [15:0] blink_age;
      logic [7:0]  clicks_running;
      logic [7:0]  clicks_total;
   } gesture_state_type;

   typedef struct {
      logic        act;
      logic        lvl;
      logic        typed;
      logic        led_a;
      logic        led_b;
      logic        held;
      logic [15:0] last;
      logic [7:0]  clicks;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'd0;  // action, button_level
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // led_a, led_b, held, last_press_ticks[15:0], clicks_latched[7:0]
   logic [31:0] rsp_tdata;
   logic        csr_we = 1'b0;
   logic [bgc_pkg::CSR_ADDR_WIDTH-1:0] csr_addr = bgc_pkg::REG_SHORT_LIMIT;
   logic [bgc_pkg::CSR_DATA_WIDTH-1:0] csr_wdata = '0;

   gesture_state_type   gst;
   bgc_pkg::cfg_type    csr_shadow;
   bgc_pkg::result_type pending_results[$];

   int  send_idle_pct = 0;
   int  rcv_stall_pct = 0;
   logic hold_request = 1'b0;
   logic hold_done = 1'b0;
   int  hold_left = 0;
   int  quiet_cycles = 0;
   int  mismatches = 0;
   int  words_sent = 0;
   int  results_checked = 0;
   int  settings_loaded = 0;
   int  n_clicks = 0;
   int  n_mid_presses = 0;
   int  n_long_presses = 0;
   int  n_windows_closed = 0;

   stim_row_type directed_rows [18] = '{
      '{1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 16'd0, 8'd0},
      '{1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 16'd0, 8'd0},
      '{1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 16'd0, 8'd0},
      '{1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 16'd0, 8'd0},
      '{1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 16'd1, 8'd0},
      '{1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 16'd2, 8'd0},
      '{1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 16'd2, 8'd0},
      '{1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 16'd2, 8'd0},
      '{1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 16'd2, 8'd0},
      '{1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 16'd2, 8'd0},
      '{1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 16'd0, 8'd0},
      '{1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 16'd0, 8'd0},
      '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 16'd0, 8'd0},
      '{1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 16'd0, 8'd0},
      '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 16'd0, 8'd0},
      '{1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 16'd0, 8'd0},
      '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 16'd0, 8'd0},
      '{1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 16'd0, 8'd0}
   };

   button_gesture_classifier_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic logic [15:0] inc_sat16(input logic [15:0] v);
      return (v == 16'hFFFF) ? v : v + 16'd1;
   endfunction

   function automatic bgc_pkg::mode_type classify(input logic [15:0] dur);
      if (dur > csr_shadow.long_limit) begin
         return bgc_pkg::MODE_LONG;
      end
      if (dur >= csr_shadow.short_limit) begin
         return bgc_pkg::MODE_MEDIUM;
      end
      return bgc_pkg::MODE_IDLE;
   endfunction

   function automatic void show_clicks();
      if (gst.clicks_total != 8'd0) begin
         gst.led_a = (gst.clicks_total > csr_shadow.many_clicks_limit);
         gst.led_b = (gst.clicks_total <= csr_shadow.many_clicks_limit);
      end
   endfunction

   function automatic void toggle_blink(input bgc_pkg::mode_type m);
      if (m == bgc_pkg::MODE_LONG) begin
         gst.led_b = 1'b1;
         gst.led_a = ~gst.led_a;
      end else begin
         gst.led_a = 1'b1;
         gst.led_b = ~gst.led_b;
      end
   endfunction

   function automatic bgc_pkg::result_type predict_gesture(input logic act, input logic lvl);
      bgc_pkg::result_type r;
      bgc_pkg::mode_type   m;
      if (act) begin
         if (!lvl) begin
            if (!gst.pressed) begin
               gst.pressed = 1'b1;
               gst.press_ticks = 16'd0;
            end
         end else if (gst.pressed) begin
            gst.pressed = 1'b0;
            gst.duration = gst.press_ticks;
            gst.press_ticks = 16'd0;
            if (gst.duration < csr_shadow.short_limit) begin
               n_clicks++;
               if (!gst.window_open) begin
                  gst.window_open = 1'b1;
                  gst.window_age = 16'd0;
               end
               if (gst.clicks_running != 8'hFF) begin
                  gst.clicks_running++;
               end
            end
            m = classify(gst.duration);
            if (m != bgc_pkg::MODE_IDLE) begin
               if (m == bgc_pkg::MODE_LONG) begin
                  n_long_presses++;
               end else begin
                  n_mid_presses++;
               end
               show_clicks();
               toggle_blink(m);
               gst.blink_age = 16'd0;
            end
         end
      end else begin
         if (gst.pressed) begin
            gst.press_ticks = inc_sat16(gst.press_ticks);
            gst.duration = gst.press_ticks;
         end
         if (gst.window_open) begin
            gst.window_age = inc_sat16(gst.window_age);
            if (gst.window_age >= csr_shadow.window_ticks) begin
               n_windows_closed++;
               gst.clicks_total = gst.clicks_running;
               gst.clicks_running = 8'd0;
               gst.window_open = 1'b0;
               gst.window_age = 16'd0;
            end
         end
         if (!gst.pressed && classify(gst.duration) != bgc_pkg::MODE_IDLE) begin
            gst.blink_age = inc_sat16(gst.blink_age);
            if (gst.blink_age >= csr_shadow.blink_ticks) begin
               toggle_blink(classify(gst.duration));
               gst.blink_age = 16'd0;
            end
         end
      end
      if (!gst.pressed && classify(gst.duration) == bgc_pkg::MODE_IDLE) begin
         show_clicks();
      end
      r.led_a = gst.led_a;
      r.led_b = gst.led_b;
      r.held = gst.pressed;
      r.last_press_ticks = gst.duration;
      r.clicks_latched = gst.clicks_total;
      return r;
   endfunction

   function automatic void check_field(input string fname, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("Mismatch in result %0d, %s: expected %0d, got %0d",
                     results_checked, fname, want, got);
         end
      end
   endfunction

   always @(posedge clock) begin : rsp_side
      bgc_pkg::result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("Unexpected result word %h with nothing pending", rsp_tdata);
            end
         end else begin
            want = pending_results.pop_front();
            check_field("led_a", want.led_a, rsp_tdata[0]);
            check_field("led_b", want.led_b, rsp_tdata[1]);
            check_field("held", want.held, rsp_tdata[2]);
            check_field("last_press_ticks", want.last_press_ticks, rsp_tdata[18:3]);
            check_field("clicks_latched", want.clicks_latched, rsp_tdata[26:19]);
         end
         results_checked++;
      end
      if (hold_request && !hold_done) begin
         hold_done <= 1'b1;
         hold_left <= HOLD_OFF_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rcv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic send_word(input logic act, input logic lvl, input logic typed,
                            input bgc_pkg::result_type typed_res);
      bgc_pkg::result_type pred;
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {6'd0, lvl, act};
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
      pred = predict_gesture(act, lvl);
      pending_results.push_back(typed ? typed_res : pred);
      words_sent++;
   endtask

   task automatic send_event(input logic act, input logic lvl);
      send_word(act, lvl, 1'b0, '0);
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic write_reg(input bgc_pkg::reg_index_type idx, input logic [15:0] val);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= val;
      @(posedge clock);
   endtask

   task automatic load_settings(input bgc_pkg::cfg_type c);
      write_reg(bgc_pkg::REG_SHORT_LIMIT, c.short_limit);
      write_reg(bgc_pkg::REG_LONG_LIMIT, c.long_limit);
      write_reg(bgc_pkg::REG_WINDOW_TICKS, c.window_ticks);
      write_reg(bgc_pkg::REG_BLINK_TICKS, c.blink_ticks);
      write_reg(bgc_pkg::REG_MANY_CLICKS_LIMIT, {8'($urandom), c.many_clicks_limit});
      csr_we <= 1'b0;
      csr_shadow = c;
      settings_loaded++;
   endtask

   task automatic gesture_burst();
      int dur;
      int tail;
      int k;
      if ($urandom_range(99) < 12) begin
         send_event(1'($urandom), 1'($urandom));
      end else begin
         case ($urandom_range(5))
            0: dur = int'(csr_shadow.short_limit) - 1;
            1: dur = int'(csr_shadow.short_limit);
            2: dur = int'(csr_shadow.long_limit);
            3: dur = int'(csr_shadow.long_limit) + 1;
            4: dur = 0;
            default: dur = $urandom_range(40);
         endcase
         if (dur < 0) begin
            dur = 0;
         end
         if (dur > 60) begin
            dur = $urandom_range(60);
         end
         send_event(1'b1, 1'b0);
         for (k = 0; k < dur; k++) begin
            if ($urandom_range(49) == 0) begin
               send_event(1'b1, 1'b0);
            end
            send_event(1'b0, 1'($urandom));
         end
         if ($urandom_range(19) != 0) begin
            send_event(1'b1, 1'b1);
         end
         tail = int'(csr_shadow.window_ticks) + 3 * int'(csr_shadow.blink_ticks) + 2;
         if (tail > 60) begin
            tail = 60;
         end
         tail = $urandom_range(tail);
         for (k = 0; k < tail; k++) begin
            send_event(1'b0, 1'($urandom));
         end
      end
   endtask

   task automatic run_phase(input bgc_pkg::cfg_type c, input int s_pct, input int r_pct,
                            input int n_words, input logic hold_off);
      int start;
      drain_results();
      load_settings(c);
      send_idle_pct = s_pct;
      rcv_stall_pct = r_pct;
      if (hold_off) begin
         hold_request <= 1'b1;
      end
      start = words_sent;
      while (words_sent - start < n_words) begin
         gesture_burst();
      end
   endtask

   function automatic bgc_pkg::cfg_type make_cfg(input int s, input int l, input int w,
                                                 input int b, input int m);
      bgc_pkg::cfg_type c;
      c.short_limit = 16'(s);
      c.long_limit = 16'(l);
      c.window_ticks = 16'(w);
      c.blink_ticks = 16'(b);
      c.many_clicks_limit = 8'(m);
      return c;
   endfunction

   initial begin
      bgc_pkg::result_type typed_res;
      int i;
      gst = '{default: '0};
      csr_shadow = make_cfg(bgc_pkg::SHORT_LIMIT_RESET, bgc_pkg::LONG_LIMIT_RESET,
                            bgc_pkg::WINDOW_TICKS_RESET, bgc_pkg::BLINK_TICKS_RESET,
                            bgc_pkg::MANY_CLICKS_LIMIT_RESET);
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Scripted start under the reset register values.
      foreach (directed_rows[n]) begin
         typed_res.led_a = directed_rows[n].led_a;
         typed_res.led_b = directed_rows[n].led_b;
         typed_res.held = directed_rows[n].held;
         typed_res.last_press_ticks = directed_rows[n].last;
         typed_res.clicks_latched = directed_rows[n].clicks;
         send_word(directed_rows[n].act, directed_rows[n].lvl, directed_rows[n].typed,
                   typed_res);
      end

      run_phase(make_cfg(4, 12, 20, 3, 2), 0, 0, 90, 1'b1);
      run_phase(make_cfg(0, 0, 0, 0, 0), 50, 0, 40, 1'b0);
      run_phase(make_cfg(6, 6, 0, 0, 0), 50, 0, 70, 1'b0);
      run_phase(make_cfg(5, 15, 25, 2, 255), 0, 50, 70, 1'b0);
      run_phase(make_cfg(3, 20, 10, 1, 1), 29, 29, 70, 1'b0);

      // All registers at their maximum, followed by a series of quick clicks.
      drain_results();
      load_settings(make_cfg(65535, 65535, 65535, 65535, 255));
      for (i = 0; i < 20; i++) begin
         send_event(1'b1, 1'b0);
         send_event(1'b1, 1'b1);
      end
      run_phase(make_cfg($urandom_range(10), $urandom_range(30), $urandom_range(40),
                         $urandom_range(8), $urandom_range(5)), 29, 29, 50, 1'b0);

      drain_results();
      repeat (8) @(posedge clock);
      $display("Run covered %0d event words under %0d register settings, %0d results checked.",
               words_sent, settings_loaded + 1, results_checked);
      $display("Gestures seen: %0d clicks, %0d medium and %0d long presses, %0d windows closed.",
               n_clicks, n_mid_presses, n_long_presses, n_windows_closed);
      if (mismatches == 0 && pending_results.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("%0d mismatches, %0d results missing", mismatches, pending_results.size());
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// ----- files.f -----
sv/bgc_pkg.sv
sv/bgc_csr.sv
sv/bgc_core.sv
sv/button_gesture_classifier_top.sv
tb/sv/tb_button_gesture_classifier_top.sv
